// File: design/jps_pkg.sv
// ---------------------------------------------------------------------------
// jps_pkg: shared types and constants of the jog/punch sequencer
// Phase, move and punch codes, lamp values, register indexes and reset
// values of the configuration registers.
// ---------------------------------------------------------------------------
package jps_pkg;

	// Default width of the stored X/Y targets
	localparam int unsigned POS_BITS_DEF = 16;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JOG_STEP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_SPEED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED = 3'd4;

	localparam logic [15:0] LIMIT_X_RST    = 16'hFFFF;
	localparam logic [15:0] LIMIT_Y_RST    = 16'hFFFF;
	localparam logic [15:0] JOG_STEP_RST   = 16'd100;
	localparam logic [6:0]  FAST_SPEED_RST = 7'd64;
	localparam logic [7:0]  SLOW_SPEED_RST = 8'd16;

	// Bit positions in the button and event vectors
	localparam int unsigned BTN_LEFT   = 0;
	localparam int unsigned BTN_RIGHT  = 1;
	localparam int unsigned BTN_UP     = 2;
	localparam int unsigned BTN_DOWN   = 3;
	localparam int unsigned BTN_PUNCH  = 4;
	localparam int unsigned BTN_AUTO   = 5;
	localparam int unsigned EV_REACHED = 4;
	localparam int unsigned EV_DONE    = 5;

	// Indicator lamp values
	localparam logic [3:0] LAMP_HOMING = 4'd1;
	localparam logic [3:0] LAMP_MANUAL = 4'd4;
	localparam logic [3:0] LAMP_AUTO   = 4'd8;

	typedef enum logic [2:0] {
		PH_X_FAST = 3'd0,
		PH_X_SLOW = 3'd1,
		PH_Y_FAST = 3'd2,
		PH_Y_SLOW = 3'd3,
		PH_MANUAL = 3'd4,
		PH_AUTO   = 3'd5,
		PH_FAULT  = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		MV_IDLE   = 2'd0,
		MV_WANTED = 2'd1,
		MV_SENT   = 2'd2
	} move_t;

	typedef enum logic [1:0] {
		PU_IDLE      = 2'd0,
		PU_WANTED    = 2'd1,
		PU_SENT      = 2'd2,
		PU_POSTPONED = 2'd3
	} punch_t;

endpackage

// File: design/jps_if.sv
// ---------------------------------------------------------------------------
// jps_if: channel interfaces of the jog/punch sequencer
// One interface for the control-tick beats going in, one for the result
// beats coming out; both use a valid/ready handshake.
// ---------------------------------------------------------------------------
interface jps_tick_if;
	logic valid;
	logic ready;
	logic btn_left;
	logic btn_right;
	logic btn_up;
	logic btn_down;
	logic btn_punch;
	logic btn_auto;
	logic left_switch_on;
	logic left_switch_off;
	logic top_switch_on;
	logic top_switch_off;
	logic target_reached;
	logic punch_done;

	modport source (
		output valid, btn_left, btn_right, btn_up, btn_down, btn_punch, btn_auto,
		       left_switch_on, left_switch_off, top_switch_on, top_switch_off,
		       target_reached, punch_done,
		input  ready
	);
	modport sink (
		input  valid, btn_left, btn_right, btn_up, btn_down, btn_punch, btn_auto,
		       left_switch_on, left_switch_off, top_switch_on, top_switch_off,
		       target_reached, punch_done,
		output ready
	);
endinterface

interface jps_result_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] power_x;
	logic signed [7:0] power_y;
	logic [15:0]       goal_x;
	logic [15:0]       goal_y;
	logic              move_request;
	logic              loop_start;
	logic              encoder_clear;
	logic              punch_request;
	logic [3:0]        lamp;
	logic [2:0]        phase;

	modport source (
		output valid, power_x, power_y, goal_x, goal_y, move_request, loop_start,
		       encoder_clear, punch_request, lamp, phase,
		input  ready
	);
	modport sink (
		input  valid, power_x, power_y, goal_x, goal_y, move_request, loop_start,
		       encoder_clear, punch_request, lamp, phase,
		output ready
	);
endinterface

// File: design/jog_punch_sequencer_top.sv
// ---------------------------------------------------------------------------
// jog_punch_sequencer_top: homing, jog and punch sequencer of a two-axis press
// Takes one control tick per beat and returns one result beat per tick.
// ---------------------------------------------------------------------------
// Each tick beat is decoded by one pass of compare, add and clamp logic and
// its result is held in the output register: a result appears in the cycle
// after its tick is taken, and a tick can be taken in every cycle as long
// as the output register is empty or is being drained in the same cycle.
// The only limit on throughput is the sink's ready. After reset the block
// homes X then Y (reverse fast to the switch, forward slowly off it); an
// unexpected event during homing latches the fault phase until reset.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// and should be changed only while no tick is in flight.
// ---------------------------------------------------------------------------
module jog_punch_sequencer_top
	import jps_pkg::*;
#(
	parameter int unsigned POS_BITS = POS_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	jps_tick_if.sink              tick_ch,
	jps_result_if.source          result_ch
);

	localparam int unsigned AW = ((POS_BITS > 16) ? POS_BITS : 16) + 1;

	// Jog toward zero, stopping at zero
	function automatic logic [POS_BITS-1:0] jog_dn(input logic [POS_BITS-1:0] t,
	                                               input logic [15:0] step);
		logic [AW-1:0] te;
		logic [AW-1:0] se;
		logic [AW-1:0] df;
		te = AW'(t);
		se = AW'(step);
		df = te - se;
		jog_dn = (te > se) ? df[POS_BITS-1:0] : '0;
	endfunction

	// Jog away from zero, stopping at the limit
	function automatic logic [POS_BITS-1:0] jog_up(input logic [POS_BITS-1:0] t,
	                                               input logic [15:0] lim,
	                                               input logic [15:0] step);
		logic [AW-1:0] te;
		logic [AW-1:0] le;
		logic [AW-1:0] se;
		logic [AW-1:0] gap;
		logic [AW-1:0] sum;
		te  = AW'(t);
		le  = AW'(lim);
		se  = AW'(step);
		gap = le - te;
		sum = te + se;
		jog_up = ((le > te) && (gap > se)) ? sum[POS_BITS-1:0] : le[POS_BITS-1:0];
	endfunction

	// Configuration registers
	logic [15:0]       limit_x_q;
	logic [15:0]       limit_y_q;
	logic [15:0]       jog_step_q;
	logic [6:0]        fast_speed_q;
	logic signed [7:0] slow_speed_q;

	// Sequencer state
	phase_t              phase_q, phase_d;
	move_t               move_q, move_d;
	punch_t              punch_q, punch_d;
	logic [5:0]          prev_btn_q, prev_btn_d;
	logic [POS_BITS-1:0] target_x_q, target_x_d;
	logic [POS_BITS-1:0] target_y_q, target_y_d;
	logic                pend_reached_q, pend_reached_d;
	logic                pend_done_q, pend_done_d;

	// Result computed for the current tick
	logic signed [7:0] power_x_d;
	logic signed [7:0] power_y_d;
	logic              mreq_d;
	logic              lstart_d;
	logic              eclr_d;
	logic              preq_d;
	logic [3:0]        lamp_d;

	// Output register
	logic              out_valid_q;
	logic signed [7:0] power_x_q;
	logic signed [7:0] power_y_q;
	logic [15:0]       goal_x_q;
	logic [15:0]       goal_y_q;
	logic              mreq_q;
	logic              lstart_q;
	logic              eclr_q;
	logic              preq_q;
	logic [3:0]        lamp_q;
	logic [2:0]        phase_out_q;

	logic       take;
	logic [5:0] btn;
	logic [5:0] ev;

	assign tick_ch.ready = !out_valid_q || result_ch.ready;
	assign take          = tick_ch.valid && tick_ch.ready;

	assign btn = {tick_ch.btn_auto, tick_ch.btn_punch, tick_ch.btn_down,
	              tick_ch.btn_up, tick_ch.btn_right, tick_ch.btn_left};
	assign ev  = {tick_ch.punch_done, tick_ch.target_reached, tick_ch.top_switch_off,
	              tick_ch.top_switch_on, tick_ch.left_switch_off, tick_ch.left_switch_on};

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_x_q    <= LIMIT_X_RST;
			limit_y_q    <= LIMIT_Y_RST;
			jog_step_q   <= JOG_STEP_RST;
			fast_speed_q <= FAST_SPEED_RST;
			slow_speed_q <= SLOW_SPEED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LIMIT_X:    limit_x_q    <= cfg_data;
				CFG_LIMIT_Y:    limit_y_q    <= cfg_data;
				CFG_JOG_STEP:   jog_step_q   <= cfg_data;
				CFG_FAST_SPEED: fast_speed_q <= cfg_data[6:0];
				CFG_SLOW_SPEED: slow_speed_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Next state and result of one tick
	always_comb begin
		logic run_man;
		logic auto_tick;
		logic man_r;
		logic man_d;
		run_man        = 1'b0;
		auto_tick      = 1'b0;
		man_r          = 1'b0;
		man_d          = 1'b0;
		phase_d        = phase_q;
		move_d         = move_q;
		punch_d        = punch_q;
		prev_btn_d     = prev_btn_q;
		target_x_d     = target_x_q;
		target_y_d     = target_y_q;
		pend_reached_d = pend_reached_q;
		pend_done_d    = pend_done_q;
		mreq_d         = 1'b0;
		lstart_d       = 1'b0;
		eclr_d         = 1'b0;
		preq_d         = 1'b0;
		power_x_d      = '0;
		power_y_d      = '0;
		lamp_d         = LAMP_HOMING;

		// Advance homing on the expected switch edge, fault on anything else
		case (phase_q)
			PH_X_FAST, PH_X_SLOW, PH_Y_FAST, PH_Y_SLOW: begin
				if (ev != '0) begin
					if (ev == (6'd1 << phase_q[1:0])) begin
						phase_d = phase_t'(phase_q + 3'd1);
						if (phase_q == PH_Y_SLOW) begin
							eclr_d   = 1'b1;
							lstart_d = 1'b1;
							mreq_d   = 1'b1;
							run_man  = 1'b1;
						end
					end else begin
						phase_d = PH_FAULT;
					end
				end
			end
			PH_MANUAL: begin
				man_r          = pend_reached_q || ev[EV_REACHED];
				man_d          = pend_done_q || ev[EV_DONE];
				pend_reached_d = 1'b0;
				pend_done_d    = 1'b0;
				run_man        = 1'b1;
			end
			PH_AUTO: begin
				pend_reached_d = pend_reached_q || ev[EV_REACHED];
				pend_done_d    = pend_done_q || ev[EV_DONE];
				phase_d        = PH_MANUAL;
				auto_tick      = 1'b1;
			end
			default: ;
		endcase

		// Manual handling: events, move/punch handoff, then jogs on button change
		if (run_man) begin
			prev_btn_d = btn;
			if (man_r) begin
				move_d = MV_IDLE;
				if (punch_d == PU_POSTPONED) punch_d = PU_WANTED;
			end
			if (man_d) punch_d = PU_IDLE;
			if (move_d == MV_WANTED && punch_d == PU_WANTED) punch_d = PU_POSTPONED;
			if (move_d == MV_WANTED && punch_d == PU_IDLE) begin
				move_d = MV_SENT;
				mreq_d = 1'b1;
			end
			if (punch_d == PU_WANTED && move_d == MV_IDLE) begin
				punch_d = PU_SENT;
				preq_d  = 1'b1;
			end
			if (prev_btn_q != btn) begin
				if (btn[BTN_LEFT]) begin
					target_x_d = jog_dn(target_x_d, jog_step_q);
					move_d     = MV_WANTED;
				end
				if (btn[BTN_RIGHT]) begin
					target_x_d = jog_up(target_x_d, limit_x_q, jog_step_q);
					move_d     = MV_WANTED;
				end
				if (btn[BTN_UP]) begin
					target_y_d = jog_dn(target_y_d, jog_step_q);
					move_d     = MV_WANTED;
				end
				if (btn[BTN_DOWN]) begin
					target_y_d = jog_up(target_y_d, limit_y_q, jog_step_q);
					move_d     = MV_WANTED;
				end
				if (btn[BTN_PUNCH] && punch_d == PU_IDLE) punch_d = PU_WANTED;
				if (btn[BTN_AUTO]) phase_d = PH_AUTO;
			end
		end

		// Motor drive and lamp from the updated phase
		if (auto_tick) begin
			lamp_d = LAMP_AUTO;
		end else begin
			case (phase_d)
				PH_X_FAST: power_x_d = 8'sd0 - $signed({1'b0, fast_speed_q});
				PH_X_SLOW: power_x_d = slow_speed_q;
				PH_Y_FAST: power_y_d = 8'sd0 - $signed({1'b0, fast_speed_q});
				PH_Y_SLOW: power_y_d = slow_speed_q;
				default: ;
			endcase
			if (phase_d == PH_MANUAL || phase_d == PH_AUTO) lamp_d = LAMP_MANUAL;
		end
	end

	// Hold sequencer state, advance on each accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_X_FAST;
			move_q         <= MV_IDLE;
			punch_q        <= PU_IDLE;
			prev_btn_q     <= '0;
			target_x_q     <= '0;
			target_y_q     <= '0;
			pend_reached_q <= 1'b0;
			pend_done_q    <= 1'b0;
		end else if (take) begin
			phase_q        <= phase_d;
			move_q         <= move_d;
			punch_q        <= punch_d;
			prev_btn_q     <= prev_btn_d;
			target_x_q     <= target_x_d;
			target_y_q     <= target_y_d;
			pend_reached_q <= pend_reached_d;
			pend_done_q    <= pend_done_d;
		end
	end

	// Output valid: set on a taken tick, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (take) begin
			power_x_q   <= power_x_d;
			power_y_q   <= power_y_d;
			goal_x_q    <= 16'(target_x_d);
			goal_y_q    <= 16'(target_y_d);
			mreq_q      <= mreq_d;
			lstart_q    <= lstart_d;
			eclr_q      <= eclr_d;
			preq_q      <= preq_d;
			lamp_q      <= lamp_d;
			phase_out_q <= phase_d;
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.power_x       = power_x_q;
	assign result_ch.power_y       = power_y_q;
	assign result_ch.goal_x        = goal_x_q;
	assign result_ch.goal_y        = goal_y_q;
	assign result_ch.move_request  = mreq_q;
	assign result_ch.loop_start    = lstart_q;
	assign result_ch.encoder_clear = eclr_q;
	assign result_ch.punch_request = preq_q;
	assign result_ch.lamp          = lamp_q;
	assign result_ch.phase         = phase_out_q;

	// Fault is terminal until reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FAULT |=> phase_q == PH_FAULT)
		else $error("fault phase left without reset");

	// A move and a punch are never commanded on the same tick
	a_no_move_and_punch: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(mreq_q && preq_q))
		else $error("move and punch requested together");

	// Homing completion pulses come together
	a_homing_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && eclr_q) |-> (lstart_q && mreq_q &&
			(phase_out_q == PH_MANUAL || phase_out_q == PH_AUTO)))
		else $error("encoder clear without loop start and move request");

	// Motors run only while homing
	a_power_homing_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (phase_out_q == PH_MANUAL || phase_out_q == PH_AUTO ||
			phase_out_q == PH_FAULT)) |-> (power_x_q == 8'sd0 && power_y_q == 8'sd0))
		else $error("motor power outside homing");

endmodule
